/* hdl/rsd_pkg.sv */
// Shared constants, types and microprogram for the RLE stream decoder.
package rsd_pkg;

  localparam int BUFFER_CAPACITY = 262144;
  localparam int PACK_BYTES      = 8;
  localparam int CNT_W           = 19;
  localparam int COUNT_MAX       = (1 << CNT_W) - 1;
  localparam int STORE_LIMIT     = (BUFFER_CAPACITY < COUNT_MAX) ? BUFFER_CAPACITY : COUNT_MAX;
  localparam int ROOM_W          = CNT_W + 1;
  localparam int RUN_W           = 8;
  localparam int CHUNK_W         = 4;
  localparam int OFFSET_W        = 18;
  localparam int REPEAT_BIAS     = 3;
  localparam int LITERAL_FLAG    = 7;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CONTROL,
    PH_LITERAL,
    PH_REPEAT,
    PH_DONE
  } phase_t;

  typedef logic [2:0] upc_t;

  localparam upc_t S_FETCH = 3'd0;
  localparam upc_t S_DISP  = 3'd1;
  localparam upc_t S_HDR   = 3'd2;
  localparam upc_t S_CTL   = 3'd3;
  localparam upc_t S_LIT   = 3'd4;
  localparam upc_t S_REP   = 3'd5;
  localparam upc_t S_EMIT  = 3'd6;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_HDR,
    OP_CTL,
    OP_LIT,
    OP_REP,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    JC_ALWAYS,
    JC_ACCEPT,
    JC_PHASE,
    JC_EMIT
  } jcond_t;

  typedef struct packed {
    logic   in_rdy;
    op_t    op;
    jcond_t cond;
    upc_t   target;
  } cword_t;

  typedef struct packed {
    logic   accept;
    phase_t phase;
    logic   emit_end;
  } seq_stat_t;

  function automatic cword_t ucode(upc_t addr);
    cword_t cw;
    case (addr)
      S_FETCH: cw = '{in_rdy: 1'b1, op: OP_LOAD, cond: JC_ACCEPT, target: S_DISP};
      S_DISP:  cw = '{in_rdy: 1'b0, op: OP_NOP,  cond: JC_PHASE,  target: S_FETCH};
      S_HDR:   cw = '{in_rdy: 1'b0, op: OP_HDR,  cond: JC_ALWAYS, target: S_FETCH};
      S_CTL:   cw = '{in_rdy: 1'b0, op: OP_CTL,  cond: JC_ALWAYS, target: S_FETCH};
      S_LIT:   cw = '{in_rdy: 1'b0, op: OP_LIT,  cond: JC_ALWAYS, target: S_EMIT};
      S_REP:   cw = '{in_rdy: 1'b0, op: OP_REP,  cond: JC_ALWAYS, target: S_EMIT};
      S_EMIT:  cw = '{in_rdy: 1'b0, op: OP_EMIT, cond: JC_EMIT,   target: S_FETCH};
      default: cw = '{in_rdy: 1'b0, op: OP_NOP,  cond: JC_ALWAYS, target: S_FETCH};
    endcase
    return cw;
  endfunction

  function automatic upc_t phase_entry(phase_t ph);
    upc_t a;
    case (ph)
      PH_HEADER:  a = S_HDR;
      PH_CONTROL: a = S_CTL;
      PH_LITERAL: a = S_LIT;
      PH_REPEAT:  a = S_REP;
      default:    a = S_FETCH;
    endcase
    return a;
  endfunction

endpackage

/* hdl/rsd_if.sv */
// Stream channel interfaces for compressed input bytes and decoded output words.
interface rsd_in_if;
  logic       valid;
  logic       ready;
  logic       stream_start;
  logic [7:0] data_byte;

  modport source (output valid, output stream_start, output data_byte, input ready);
  modport sink (input valid, input stream_start, input data_byte, output ready);
endinterface

interface rsd_out_if;
  logic                          valid;
  logic                          ready;
  logic [8*rsd_pkg::PACK_BYTES-1:0] packed_bytes;
  logic [rsd_pkg::CHUNK_W-1:0]   byte_count;
  logic [rsd_pkg::OFFSET_W-1:0]  out_offset;
  logic                          item_last;
  logic                          stream_done;
  logic                          overflow;

  modport source (output valid, output packed_bytes, output byte_count, output out_offset,
                  output item_last, output stream_done, output overflow, input ready);
  modport sink (input valid, input packed_bytes, input byte_count, input out_offset,
                input item_last, input stream_done, input overflow, output ready);
endinterface

/* hdl/rsd_seq.sv */
// Microcode sequencer: step counter, control ROM and conditional jump logic.
module rsd_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  rsd_pkg::seq_stat_t stat,
  output rsd_pkg::cword_t    cw
);

  rsd_pkg::upc_t upc_r;
  rsd_pkg::upc_t upc_nxt;

  assign cw = rsd_pkg::ucode(upc_r);

  always_comb begin
    case (cw.cond)
      rsd_pkg::JC_ALWAYS: upc_nxt = cw.target;
      rsd_pkg::JC_ACCEPT: upc_nxt = stat.accept ? cw.target : upc_r;
      rsd_pkg::JC_PHASE:  upc_nxt = rsd_pkg::phase_entry(stat.phase);
      rsd_pkg::JC_EMIT:   upc_nxt = stat.emit_end ? cw.target : upc_r;
      default:            upc_nxt = rsd_pkg::S_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= rsd_pkg::S_FETCH;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

/* hdl/rle_stream_decoder.sv */
// RLE stream decoder top level: datapath, output register and sequencer instance.
// Each compressed byte passes through a microprogram of fetch, dispatch and one
// operation step (none once the stream is done); a literal or repeat value byte
// then adds an emit step that sends ceil(stored/8) packed words, where stored is the
// number of run bytes kept in the buffer range. The emit step loads one packed word
// per cycle into the single output register, so a stalled output stretches that
// step. The next byte is taken while the last word of the previous one waits.
module rle_stream_decoder (
  input logic       clk,
  input logic       rst_n,
  rsd_in_if.sink    in_ch,
  rsd_out_if.source out_ch
);

  localparam int PB = rsd_pkg::PACK_BYTES;

  rsd_pkg::cword_t    cw;
  rsd_pkg::seq_stat_t stat;

  rsd_pkg::phase_t                phase_r, phase_nxt;
  logic [1:0]                     hdr_r, hdr_nxt;
  logic [31:0]                    target_r, target_nxt;
  logic [rsd_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [rsd_pkg::RUN_W-1:0]      lit_r, lit_nxt;
  logic [rsd_pkg::RUN_W-1:0]      rep_r, rep_nxt;
  logic                           ovf_r, ovf_nxt;
  logic [rsd_pkg::RUN_W-1:0]      left_r, left_nxt;
  logic [rsd_pkg::CNT_W-1:0]      pos_r, pos_nxt;
  logic [7:0]                     byte_r, byte_nxt;
  logic                           oval_r, oval_nxt;
  logic [8*PB-1:0]                odata_r, odata_nxt;
  logic [rsd_pkg::CHUNK_W-1:0]    ocnt_r, ocnt_nxt;
  logic [rsd_pkg::OFFSET_W-1:0]   ooff_r, ooff_nxt;
  logic                           olast_r, olast_nxt;
  logic                           odone_r, odone_nxt;
  logic                           oovf_r, oovf_nxt;

  logic                           accept;
  logic                           out_busy;
  logic [rsd_pkg::RUN_W-1:0]      run_n;
  logic [rsd_pkg::ROOM_W-1:0]     room;
  logic                           in_range;
  logic [rsd_pkg::RUN_W-1:0]      stored;
  logic [rsd_pkg::ROOM_W-1:0]     sum;
  logic [rsd_pkg::CNT_W-1:0]      cnt_new;
  rsd_pkg::phase_t                fin_phase;
  logic [rsd_pkg::CHUNK_W-1:0]    chunk;
  logic [8*PB-1:0]                lanes;
  logic [rsd_pkg::RUN_W-1:0]      lit_dec;

  assign accept      = in_ch.valid && cw.in_rdy;
  assign in_ch.ready = cw.in_rdy;
  assign out_busy    = oval_r && !out_ch.ready;

  assign stat.accept   = accept;
  assign stat.phase    = phase_r;
  assign stat.emit_end = (left_r == '0) || (!out_busy && (left_r <= rsd_pkg::RUN_W'(PB)));

  rsd_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cw    (cw)
  );

  // run setup shared by literal and repeat steps
  always_comb begin
    run_n    = (cw.op == rsd_pkg::OP_LIT) ? rsd_pkg::RUN_W'(1) : rep_r;
    in_range = {1'b0, count_r} < rsd_pkg::ROOM_W'(rsd_pkg::STORE_LIMIT);
    room     = rsd_pkg::ROOM_W'(rsd_pkg::STORE_LIMIT) - {1'b0, count_r};
    if (!in_range) begin
      stored = '0;
    end else if (room < rsd_pkg::ROOM_W'(run_n)) begin
      stored = room[rsd_pkg::RUN_W-1:0];
    end else begin
      stored = run_n;
    end
    sum       = {1'b0, count_r} + rsd_pkg::ROOM_W'(run_n);
    cnt_new   = (sum > rsd_pkg::ROOM_W'(rsd_pkg::COUNT_MAX)) ?
                rsd_pkg::CNT_W'(rsd_pkg::COUNT_MAX) : sum[rsd_pkg::CNT_W-1:0];
    fin_phase = (32'(cnt_new) >= target_r) ? rsd_pkg::PH_DONE : rsd_pkg::PH_CONTROL;
    lit_dec   = lit_r - rsd_pkg::RUN_W'(1);
  end

  always_comb begin
    chunk = (left_r < rsd_pkg::RUN_W'(PB)) ? left_r[rsd_pkg::CHUNK_W-1:0] :
            rsd_pkg::CHUNK_W'(PB);
    for (int i = 0; i < PB; i++) begin
      lanes[8*i +: 8] = (rsd_pkg::CHUNK_W'(i) < chunk) ? byte_r : 8'h00;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    hdr_nxt    = hdr_r;
    target_nxt = target_r;
    count_nxt  = count_r;
    lit_nxt    = lit_r;
    rep_nxt    = rep_r;
    ovf_nxt    = ovf_r;
    left_nxt   = left_r;
    pos_nxt    = pos_r;
    byte_nxt   = byte_r;
    oval_nxt   = oval_r && !out_ch.ready;
    odata_nxt  = odata_r;
    ocnt_nxt   = ocnt_r;
    ooff_nxt   = ooff_r;
    olast_nxt  = olast_r;
    odone_nxt  = odone_r;
    oovf_nxt   = oovf_r;

    case (cw.op)
      rsd_pkg::OP_LOAD: begin
        if (accept) begin
          byte_nxt = in_ch.data_byte;
          if (in_ch.stream_start) begin
            phase_nxt  = rsd_pkg::PH_HEADER;
            hdr_nxt    = '0;
            target_nxt = '0;
            count_nxt  = '0;
            lit_nxt    = '0;
            rep_nxt    = '0;
            ovf_nxt    = 1'b0;
          end
        end
      end
      rsd_pkg::OP_HDR: begin
        target_nxt = target_r | (32'(byte_r) << {hdr_r, 3'b000});
        hdr_nxt    = hdr_r + 2'd1;
        if (hdr_r == 2'd3) begin
          phase_nxt = (32'(count_r) >= target_nxt) ? rsd_pkg::PH_DONE : rsd_pkg::PH_CONTROL;
        end
      end
      rsd_pkg::OP_CTL: begin
        if (byte_r[rsd_pkg::LITERAL_FLAG]) begin
          lit_nxt   = {1'b0, byte_r[6:0]} + rsd_pkg::RUN_W'(1);
          phase_nxt = rsd_pkg::PH_LITERAL;
        end else begin
          rep_nxt   = byte_r + rsd_pkg::RUN_W'(rsd_pkg::REPEAT_BIAS);
          phase_nxt = rsd_pkg::PH_REPEAT;
        end
      end
      rsd_pkg::OP_LIT, rsd_pkg::OP_REP: begin
        left_nxt  = stored;
        pos_nxt   = count_r;
        count_nxt = cnt_new;
        if (stored < run_n) begin
          ovf_nxt = 1'b1;
        end
        if (cw.op == rsd_pkg::OP_LIT) begin
          lit_nxt = lit_dec;
          if (lit_dec == '0) begin
            phase_nxt = fin_phase;
          end
        end else begin
          rep_nxt   = '0;
          phase_nxt = fin_phase;
        end
      end
      rsd_pkg::OP_EMIT: begin
        if (left_r != '0 && !out_busy) begin
          oval_nxt  = 1'b1;
          odata_nxt = lanes;
          ocnt_nxt  = chunk;
          ooff_nxt  = pos_r[rsd_pkg::OFFSET_W-1:0];
          olast_nxt = (left_r <= rsd_pkg::RUN_W'(PB));
          odone_nxt = (phase_r == rsd_pkg::PH_DONE);
          oovf_nxt  = ovf_r;
          left_nxt  = left_r - rsd_pkg::RUN_W'(chunk);
          pos_nxt   = pos_r + rsd_pkg::CNT_W'(chunk);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= rsd_pkg::PH_DONE;
      hdr_r    <= '0;
      target_r <= '0;
      count_r  <= '0;
      lit_r    <= '0;
      rep_r    <= '0;
      ovf_r    <= 1'b0;
      left_r   <= '0;
      oval_r   <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      hdr_r    <= hdr_nxt;
      target_r <= target_nxt;
      count_r  <= count_nxt;
      lit_r    <= lit_nxt;
      rep_r    <= rep_nxt;
      ovf_r    <= ovf_nxt;
      left_r   <= left_nxt;
      oval_r   <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    byte_r  <= byte_nxt;
    odata_r <= odata_nxt;
    ocnt_r  <= ocnt_nxt;
    ooff_r  <= ooff_nxt;
    olast_r <= olast_nxt;
    odone_r <= odone_nxt;
    oovf_r  <= oovf_nxt;
  end

  assign out_ch.valid        = oval_r;
  assign out_ch.packed_bytes = odata_r;
  assign out_ch.byte_count   = ocnt_r;
  assign out_ch.out_offset   = ooff_r;
  assign out_ch.item_last    = olast_r;
  assign out_ch.stream_done  = odone_r;
  assign out_ch.overflow     = oovf_r;

endmodule
